// ===== rtl/kcshws_pkg.sv =====
// kcshws_pkg: shared types and constants of the kcs host write sequencer
// no dependencies; used by kcshws_cfg, kcshws_core and the top level
`default_nettype none

package kcshws_pkg;

    // kind codes of an input word
    localparam logic [1:0] KIND_MSG    = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // action and result codes of an output word
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_DONE  = 1'b1;
    localparam logic RES_OK    = 1'b0;
    localparam logic RES_FAIL  = 1'b1;

    // kcs command bytes and status bits
    localparam logic [7:0] CMD_ABORT       = 8'h60;
    localparam logic [7:0] CMD_WRITE_START = 8'h61;
    localparam logic [7:0] CMD_WRITE_END   = 8'h62;
    localparam int         STS_OBF_BIT     = 0;
    localparam int         STS_IBF_BIT     = 1;

    // register map
    localparam int         APB_AW         = 4;
    localparam logic [1:0] REG_IO_BASE    = 2'd0;
    localparam logic [1:0] REG_NETFN_LUN  = 2'd1;
    localparam logic [1:0] REG_TIMEOUT    = 2'd2;

    localparam logic [15:0] RST_IO_BASE   = 16'h0ca2;
    localparam logic [7:0]  RST_NETFN_LUN = 8'h18;
    localparam logic [15:0] RST_TIMEOUT   = 16'd50;

    typedef struct packed {
        logic [15:0] io_base_address;
        logic [7:0]  netfn_lun;
        logic [15:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] msg_byte;
        logic       msg_last;
        logic [7:0] status_value;
    } t_item;

    typedef struct packed {
        logic        action;
        logic [15:0] write_address;
        logic [7:0]  write_value;
        logic        read_before;
        logic        read_after;
        logic        result_code;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/kcshws_intf.sv =====
// kcshws_in_if / kcshws_out_if: valid/ready channels of the sequencer
// no dependencies
`default_nettype none

interface kcshws_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] msg_byte;
    logic       msg_last;
    logic [7:0] status_value;

    modport source (output valid, kind, msg_byte, msg_last, status_value, input ready);
    modport sink   (input valid, kind, msg_byte, msg_last, status_value, output ready);
endinterface

interface kcshws_out_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [15:0] write_address;
    logic [7:0]  write_value;
    logic        read_before;
    logic        read_after;
    logic        result_code;

    modport source (output valid, action, write_address, write_value, read_before,
                    read_after, result_code, input ready);
    modport sink   (input valid, action, write_address, write_value, read_before,
                    read_after, result_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/kcshws_ram.sv =====
// kcshws_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module kcshws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/kcshws_cfg.sv =====
// kcshws_cfg: apb register block holding the port address, netfn/lun and timeout
// depends on kcshws_pkg
`default_nettype none

module kcshws_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kcshws_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output kcshws_pkg::t_cfg                   o_cfg
);
    import kcshws_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.io_base_address <= RST_IO_BASE;
            r_cfg.netfn_lun       <= RST_NETFN_LUN;
            r_cfg.timeout_ticks   <= RST_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_IO_BASE:   r_cfg.io_base_address <= pwdata[15:0];
                REG_NETFN_LUN: r_cfg.netfn_lun       <= pwdata[7:0];
                REG_TIMEOUT:   r_cfg.timeout_ticks   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_IO_BASE:   prdata = {16'd0, r_cfg.io_base_address};
            REG_NETFN_LUN: prdata = {24'd0, r_cfg.netfn_lun};
            REG_TIMEOUT:   prdata = {16'd0, r_cfg.timeout_ticks};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/kcshws_core.sv =====
// kcshws_core: transfer state machine, message store and per-word result logic
// depends on kcshws_pkg and kcshws_ram
`default_nettype none

module kcshws_core #(
    parameter int MAX_MESSAGE = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_step,
    input  wire kcshws_pkg::t_item    i_item,
    input  wire kcshws_pkg::t_cfg     i_cfg,
    output logic                      o_produce,
    output kcshws_pkg::t_result       o_result
);
    import kcshws_pkg::*;

    localparam int AW = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
    localparam int CW = $clog2(MAX_MESSAGE + 1);
    localparam int PW = $clog2(MAX_MESSAGE + 4);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SEND,
        PH_DONEWAIT,
        PH_REC1,
        PH_REC2
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [CW-1:0] r_count, n_count, cnt_inc;
    logic [PW-1:0] r_pos, n_pos;
    logic [15:0]   r_elapsed, n_elapsed, e_new;

    logic [PW-1:0] cnt_ext, pos_inc, n_cnt_ext, rd_idx;
    logic [7:0]    rd_data;
    logic          wr_en;
    logic [15:0]   cmd_addr;
    logic [15:0]   sn_addr;
    logic [7:0]    sn_val;
    logic          sts_err, ibf_clear, obf_set, timed_out, busy_phase;
    logic          wait_fail, end_rec;

    // message store, read address follows the next state so data is ready
    kcshws_ram #(
        .WIDTH (8),
        .DEPTH (MAX_MESSAGE)
    ) u_msg_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_item.msg_byte),
        .i_rd_addr (rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign n_cnt_ext = PW'(n_count);
    assign rd_idx    = (n_pos <= n_cnt_ext) ? (n_pos - PW'(2)) : (n_cnt_ext - PW'(1));

    // status decode and tick counting
    assign cmd_addr   = i_cfg.io_base_address + 16'd1;
    assign sts_err    = i_item.status_value[7] && i_item.status_value[6];
    assign ibf_clear  = !i_item.status_value[STS_IBF_BIT];
    assign obf_set    = i_item.status_value[STS_OBF_BIT];
    assign e_new      = (i_item.kind == KIND_TICK && r_elapsed != 16'hffff)
                        ? r_elapsed + 16'd1 : r_elapsed;
    assign timed_out  = e_new >= i_cfg.timeout_ticks;
    assign busy_phase = (r_phase == PH_SEND) || (r_phase == PH_DONEWAIT);

    // next byte of the write sequence
    assign cnt_ext = PW'(r_count);
    assign cnt_inc = r_count + CW'(1);
    assign pos_inc = r_pos + PW'(1);
    always_comb begin
        sn_addr = i_cfg.io_base_address;
        if (r_pos == PW'(0)) begin
            sn_addr = cmd_addr;
            sn_val  = CMD_WRITE_START;
        end else if (r_pos == PW'(1)) begin
            sn_val  = i_cfg.netfn_lun;
        end else if (r_pos <= cnt_ext) begin
            sn_val  = rd_data;
        end else if (r_pos == cnt_ext + PW'(1)) begin
            sn_addr = cmd_addr;
            sn_val  = CMD_WRITE_END;
        end else begin
            sn_val  = rd_data;
        end
    end

    // per-word state update and result
    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_pos     = r_pos;
        n_elapsed = r_elapsed;
        o_produce = 1'b0;
        o_result  = '0;
        wr_en     = 1'b0;
        wait_fail = 1'b0;
        end_rec   = 1'b0;
        if (i_step) begin
            if (r_phase == PH_IDLE) begin
                if (i_item.kind == KIND_MSG) begin
                    if (r_count < CW'(MAX_MESSAGE)) begin
                        wr_en   = 1'b1;
                        n_count = cnt_inc;
                    end
                    if (i_item.msg_last && n_count != CW'(0)) begin
                        n_phase   = PH_SEND;
                        n_pos     = '0;
                        n_elapsed = '0;
                    end
                end
            end else begin
                case (i_item.kind)
                    KIND_STATUS: begin
                        if (sts_err) begin
                            wait_fail = 1'b1;
                        end else if (r_phase == PH_SEND && ibf_clear) begin
                            o_produce                = 1'b1;
                            o_result.action          = ACT_WRITE;
                            o_result.write_address   = sn_addr;
                            o_result.write_value     = sn_val;
                            o_result.read_after      = 1'b1;
                            n_pos                    = pos_inc;
                            if (pos_inc >= cnt_ext + PW'(3)) begin
                                n_phase = PH_DONEWAIT;
                            end
                        end else if (r_phase == PH_DONEWAIT && obf_set) begin
                            o_produce            = 1'b1;
                            o_result.action      = ACT_DONE;
                            o_result.result_code = RES_OK;
                            n_phase              = PH_IDLE;
                            n_count              = '0;
                            n_pos                = '0;
                        end else if (r_phase == PH_REC1 && ibf_clear) begin
                            o_produce              = 1'b1;
                            o_result.action        = ACT_WRITE;
                            o_result.write_address = i_cfg.io_base_address;
                            o_result.read_before   = obf_set;
                            n_phase                = PH_REC2;
                        end else if (r_phase == PH_REC2 && ibf_clear) begin
                            end_rec = 1'b1;
                        end else if (timed_out) begin
                            wait_fail = 1'b1;
                        end
                    end
                    KIND_TICK: begin
                        n_elapsed = e_new;
                        wait_fail = timed_out;
                    end
                    default: begin
                    end
                endcase
                // failed wait: abort during the transfer, else leave recovery
                if (wait_fail) begin
                    if (busy_phase) begin
                        o_produce              = 1'b1;
                        o_result.action        = ACT_WRITE;
                        o_result.write_address = cmd_addr;
                        o_result.write_value   = CMD_ABORT;
                        n_phase                = PH_REC1;
                    end else begin
                        end_rec = 1'b1;
                    end
                end
                // end of recovery: give up once timed out, else retry
                if (end_rec) begin
                    n_pos = '0;
                    if (timed_out) begin
                        o_produce            = 1'b1;
                        o_result.action      = ACT_DONE;
                        o_result.result_code = RES_FAIL;
                        n_phase              = PH_IDLE;
                        n_count              = '0;
                    end else begin
                        n_phase = PH_SEND;
                    end
                end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_count   <= '0;
            r_pos     <= '0;
            r_elapsed <= '0;
        end else begin
            r_phase   <= n_phase;
            r_count   <= n_count;
            r_pos     <= n_pos;
            r_elapsed <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kcs_host_write_sequencer.sv =====
// kcs_host_write_sequencer: top level with input register, core and result register
// depends on kcshws_pkg, kcshws_intf, kcshws_cfg, kcshws_core, kcshws_ram
//
//   channel   dir   handshake       payload
//   in_ch     in    valid/ready     kind, msg_byte, msg_last, status_value
//   out_ch    out   valid/ready     action, write_address, write_value,
//                                   read_before, read_after, result_code
//   apb       in    psel/penable    paddr, pwdata, prdata (pready tied high)
//
// one word per cycle unless out_ch stalls: a word is held in the input register, is
// handled by the core state machine and any result lands in the result register.
// the message store read is prefetched from the next state, so its data is ready in time.
// synchronous active-low reset clears the state machine and both valid flags.
// a full result register that is not taken stalls the input register and then in_ch.
`default_nettype none

module kcs_host_write_sequencer #(
    parameter int MAX_MESSAGE = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    kcshws_in_if.sink                          in_ch,
    kcshws_out_if.source                       out_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [kcshws_pkg::APB_AW-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);
    import kcshws_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out, core_res;
    logic    r_out_valid;
    logic    advance, core_produce;

    kcshws_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // the held word moves on when the result register is free or being drained
    assign advance     = r_in_valid && (!r_out_valid || out_ch.ready);
    assign in_ch.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ch.valid && in_ch.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_ch.valid && in_ch.ready) begin
            r_in.kind         <= in_ch.kind;
            r_in.msg_byte     <= in_ch.msg_byte;
            r_in.msg_last     <= in_ch.msg_last;
            r_in.status_value <= in_ch.status_value;
        end
    end

    kcshws_core #(
        .MAX_MESSAGE (MAX_MESSAGE)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_item    (r_in),
        .i_cfg     (cfg),
        .o_produce (core_produce),
        .o_result  (core_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= core_produce;
        end else if (out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && core_produce) begin
            r_out <= core_res;
        end
    end

    assign out_ch.valid         = r_out_valid;
    assign out_ch.action        = r_out.action;
    assign out_ch.write_address = r_out.write_address;
    assign out_ch.write_value   = r_out.write_value;
    assign out_ch.read_before   = r_out.read_before;
    assign out_ch.read_after    = r_out.read_after;
    assign out_ch.result_code   = r_out.result_code;

    // checks
    a_finish_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.action == ACT_DONE |->
            out_ch.write_address == 16'd0 && out_ch.write_value == 8'd0 &&
            !out_ch.read_before && !out_ch.read_after)
        else $error("finish word carries write fields");

    a_flush_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.read_before |->
            out_ch.write_value == 8'd0 && !out_ch.read_after &&
            out_ch.action == ACT_WRITE)
        else $error("flush write is not a plain zero data write");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ch.ready |-> r_in_valid && r_out_valid && !out_ch.ready)
        else $error("input stalled without a stalled result");

endmodule

`default_nettype wire
